@@ hw/rtl/gdi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gregorian date info package
// Request and result types, stage payloads, calendar tables and the
// reciprocal constants used for the divisions by 100 and by 7.
// ----------------------------------------------------------------------------
package gdi_pkg;

    localparam logic [13:0] YEAR_MIN     = 14'd1900;
    localparam logic [3:0]  MONTH_JAN    = 4'd1;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_MAR    = 4'd3;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y.
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [6:0]  CENTURY      = 7'd100;
    // floor(s / 7) == (s * 37450) >> 18 for every 15-bit s.
    localparam logic [15:0] DIV7_MUL     = 16'd37450;
    localparam int          DIV7_SHIFT   = 18;
    localparam logic [2:0]  WEEK_DAYS    = 3'd7;

    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [13:0] year_number;
    } t_date_req;

    typedef struct packed {
        logic        date_valid;
        logic        leap_flag;
        logic [8:0]  ordinal_day;
        logic [4:0]  month_length;
        logic [2:0]  weekday_code;
    } t_date_info;

    // After the first stage: raw fields, weekday year, scaled years and the range check.
    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [13:0] year_number;
        logic [13:0] wk_year;
        logic [26:0] year_scaled;
        logic [26:0] wk_year_scaled;
        logic        base_ok;
    } t_yr_data;

    // After the calendar stage: everything but the weekday remainder.
    typedef struct packed {
        logic        date_valid;
        logic        leap_flag;
        logic [8:0]  ordinal_day;
        logic [4:0]  month_length;
        logic [14:0] day_sum;
    } t_cal_data;

    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] month);
        logic [8:0] cnt;
        unique case (month)
            4'd1:    cnt = 9'd0;
            4'd2:    cnt = 9'd31;
            4'd3:    cnt = 9'd59;
            4'd4:    cnt = 9'd90;
            4'd5:    cnt = 9'd120;
            4'd6:    cnt = 9'd151;
            4'd7:    cnt = 9'd181;
            4'd8:    cnt = 9'd212;
            4'd9:    cnt = 9'd243;
            4'd10:   cnt = 9'd273;
            4'd11:   cnt = 9'd304;
            4'd12:   cnt = 9'd334;
            default: cnt = 9'd0;
        endcase
        return cnt;
    endfunction

    // Month offsets of the Sakamoto weekday formula.
    function automatic logic [2:0] week_offset(input logic [3:0] month);
        logic [2:0] off;
        unique case (month)
            4'd1, 4'd5:   off = 3'd0;
            4'd2, 4'd6:   off = 3'd3;
            4'd3, 4'd11:  off = 3'd2;
            4'd4, 4'd7:   off = 3'd5;
            4'd8:         off = 3'd1;
            4'd9, 4'd12:  off = 3'd4;
            4'd10:        off = 3'd6;
            default:      off = 3'd0;
        endcase
        return off;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/gregorian_date_info.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gregorian date info
// Validity, leap year, ordinal day, month length and weekday of one date.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   i_valid / o_stall    i_req  (t_date_req)
//  result    o_valid / i_stall    o_rsp  (t_date_info)
//
// One request enters per cycle while o_stall is low.
// The four register stages are year preparation, calendar, weekday
// multiply and weekday correction.
// Reset clears only the stage valid bits; the data registers keep their contents.
// A stall holds only the stages that are occupied, so bubbles still fill.
// ----------------------------------------------------------------------------
module gregorian_date_info (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire gdi_pkg::t_date_req i_req,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output gdi_pkg::t_date_info     o_rsp
);
    import gdi_pkg::*;

    logic      yr_valid;
    logic      yr_stall;
    t_yr_data  yr_data;
    logic      cal_valid;
    logic      cal_stall;
    t_cal_data cal_data;

    gdi_year_prep u_year_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (yr_valid),
        .i_stall (yr_stall),
        .o_data  (yr_data)
    );

    gdi_calendar u_calendar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (yr_valid),
        .o_stall (yr_stall),
        .i_data  (yr_data),
        .o_valid (cal_valid),
        .i_stall (cal_stall),
        .o_data  (cal_data)
    );

    gdi_weekday u_weekday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cal_valid),
        .o_stall (cal_stall),
        .i_data  (cal_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    // An invalid date must not leak any computed field.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.date_valid) |->
            (!o_rsp.leap_flag && o_rsp.ordinal_day == 9'd0 &&
             o_rsp.month_length == 5'd0 && o_rsp.weekday_code == 3'd0))
        else $error("invalid date with nonzero fields");

    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.date_valid) |-> (o_rsp.weekday_code < WEEK_DAYS))
        else $error("weekday out of range");

    a_ordinal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.date_valid) |->
            (o_rsp.ordinal_day != 9'd0 &&
             o_rsp.ordinal_day <= 9'd365 + 9'(o_rsp.leap_flag)))
        else $error("ordinal day out of range");

    a_month_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.date_valid) |->
            (o_rsp.month_length >= 5'd28 && o_rsp.month_length <= 5'd31 &&
             (o_rsp.month_length != 5'd29 || o_rsp.leap_flag)))
        else $error("month length inconsistent with leap flag");

endmodule
`default_nettype wire

@@ hw/rtl/gdi_year_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Year preparation stage
// Range checks on the raw fields and the constant multiplications that
// later yield the century counts of the year and of the weekday year.
// ----------------------------------------------------------------------------
module gdi_year_prep (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire gdi_pkg::t_date_req i_req,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output gdi_pkg::t_yr_data      o_data
);
    import gdi_pkg::*;

    logic     r_valid;
    t_yr_data r_data;
    t_yr_data n_data;

    assign o_stall = r_valid & i_stall;

    always_comb begin
        n_data.month          = i_req.month;
        n_data.day_of_month   = i_req.day_of_month;
        n_data.year_number    = i_req.year_number;
        // January and February count toward the previous year for the weekday.
        n_data.wk_year        = (i_req.month < MONTH_MAR) ? (i_req.year_number - 14'd1)
                                                          : i_req.year_number;
        n_data.year_scaled    = 27'(i_req.year_number) * 27'(DIV100_MUL);
        n_data.wk_year_scaled = 27'(n_data.wk_year) * 27'(DIV100_MUL);
        n_data.base_ok        = (i_req.year_number >= YEAR_MIN) &&
                                (i_req.month >= MONTH_JAN) && (i_req.month <= MONTH_DEC) &&
                                (i_req.day_of_month != 5'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

@@ hw/rtl/gdi_calendar.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar stage
// Leap year, month length, validity, ordinal day and the weekday day sum.
// ----------------------------------------------------------------------------
module gdi_calendar (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire gdi_pkg::t_yr_data i_data,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output gdi_pkg::t_cal_data    o_data
);
    import gdi_pkg::*;

    logic      r_valid;
    t_cal_data r_data;
    t_cal_data n_data;

    logic [7:0]  cent;
    logic [7:0]  wk_cent;
    logic [13:0] cent_x100;
    logic        leap;
    logic [4:0]  mlen;
    logic [15:0] sum_full;

    assign o_stall = r_valid & i_stall;

    always_comb begin
        cent      = i_data.year_scaled[DIV100_SHIFT +: 8];
        wk_cent   = i_data.wk_year_scaled[DIV100_SHIFT +: 8];
        cent_x100 = 14'(cent) * 14'(CENTURY);
        // A century year is a leap year only when its century count is a multiple of 4.
        leap      = (i_data.year_number[1:0] == 2'd0) &&
                    ((cent_x100 != i_data.year_number) || (cent[1:0] == 2'd0));
        mlen      = month_days(i_data.month) +
                    5'((i_data.month == MONTH_FEB) && leap);
        sum_full  = 16'(i_data.wk_year) + 16'(i_data.wk_year[13:2]) - 16'(wk_cent) +
                    16'(wk_cent[7:2]) + 16'(week_offset(i_data.month)) +
                    16'(i_data.day_of_month);

        n_data.date_valid   = i_data.base_ok && (i_data.day_of_month <= mlen);
        n_data.leap_flag    = leap;
        n_data.ordinal_day  = days_before(i_data.month) + 9'(i_data.day_of_month) +
                              9'(leap && (i_data.month > MONTH_FEB));
        n_data.month_length = mlen;
        n_data.day_sum      = sum_full[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

@@ hw/rtl/gdi_weekday.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekday stages
// Day sum modulo 7 by reciprocal multiplication in one stage and the
// correction in the next, which also forms the output register.
// ----------------------------------------------------------------------------
module gdi_weekday (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire gdi_pkg::t_cal_data i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output gdi_pkg::t_date_info    o_rsp
);
    import gdi_pkg::*;

    logic       r_valid_m;
    t_cal_data  r_cal;
    logic [30:0] r_prod;
    logic       stall_m;

    logic       r_valid_o;
    t_date_info r_rsp;
    t_date_info n_rsp;
    logic       stall_o;

    logic [12:0] quot;
    logic [15:0] rem;

    assign stall_o = r_valid_o & i_stall;
    assign stall_m = r_valid_m & stall_o;
    assign o_stall = stall_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_m <= 1'b0;
            r_valid_o <= 1'b0;
        end else begin
            if (!stall_m) begin
                r_valid_m <= i_valid;
            end
            if (!stall_o) begin
                r_valid_o <= r_valid_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall_m && i_valid) begin
            r_cal  <= i_data;
            r_prod <= 31'(i_data.day_sum) * 31'(DIV7_MUL);
        end
    end

    always_comb begin
        quot = r_prod[DIV7_SHIFT +: 13];
        rem  = 16'(r_cal.day_sum) - 16'(quot) * 16'(WEEK_DAYS);
        // An invalid date reports zeros in every field.
        if (r_cal.date_valid) begin
            n_rsp.date_valid   = 1'b1;
            n_rsp.leap_flag    = r_cal.leap_flag;
            n_rsp.ordinal_day  = r_cal.ordinal_day;
            n_rsp.month_length = r_cal.month_length;
            n_rsp.weekday_code = rem[2:0];
        end else begin
            n_rsp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall_o && r_valid_m) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid_o;
    assign o_rsp   = r_rsp;

endmodule
`default_nettype wire
